### src/sbw_pkg.sv
// ----------------------------------------------------------------------------
// sbw_pkg: shared types and constants for the stacked boxcar waveform
// Widths, register index codes, the config bundle and one divide step.
// ----------------------------------------------------------------------------
package sbw_pkg;

    localparam int STACK_DEPTH = 4;
    localparam int PHASE_BITS  = 16;
    localparam int TIME_W      = 48;
    localparam int CYC_W       = 32;
    localparam int DIV_STEPS   = TIME_W + PHASE_BITS;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int SUM_W       = 19;

    typedef enum logic [2:0] {
        REG_CYCLE_TIME   = 3'd0,
        REG_ACTIVE_BOXES = 3'd1,
        REG_DELAYS       = 3'd2,
        REG_WIDTHS       = 3'd3,
        REG_HEIGHTS      = 3'd4,
        REG_MIN_VALUE    = 3'd5,
        REG_MAX_VALUE    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]         active_boxes;
        logic [63:0]        delays;
        logic [63:0]        widths;
        logic [63:0]        heights;
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
    } box_cfg_t;

    typedef struct packed {
        logic [CYC_W-1:0] rem;
        logic             qbit;
    } div_step_t;

    // One restoring division step: shift in a bit, subtract if it fits
    function automatic div_step_t div_step(input logic [CYC_W-1:0] rem,
                                           input logic             bit_in,
                                           input logic [CYC_W-1:0] divisor);
        logic [CYC_W:0] trial;
        div_step_t      res;
        trial = {rem, bit_in};
        if (trial >= {1'b0, divisor})
        begin
            res.rem  = CYC_W'(trial - {1'b0, divisor});
            res.qbit = 1'b1;
        end
        else
        begin
            res.rem  = trial[CYC_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

### src/sbw_phase_div.sv
// ----------------------------------------------------------------------------
// sbw_phase_div: pipelined phase divider
// One restoring step per stage over {time, zeros}; the last PHASE_BITS
// quotient bits are the phase (time mod cycle) * 2^PHASE_BITS / cycle.
// ----------------------------------------------------------------------------
module sbw_phase_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sbw_pkg::TIME_W-1:0]    time_now,
    input  logic [sbw_pkg::CYC_W-1:0]     divisor,
    input  logic                          q_full,
    output logic                          push,
    output logic [sbw_pkg::PHASE_BITS-1:0] phase
);
    import sbw_pkg::*;

    logic                  valid_reg [0:DIV_STEPS-1];
    logic [CYC_W-1:0]      rem_reg   [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0]  num_reg   [0:DIV_STEPS-1];
    logic [PHASE_BITS-1:0] quo_reg   [0:DIV_STEPS-1];
    div_step_t             step      [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0]  num_in;
    logic                  advance;

    // Hold the whole pipe only when its last stage cannot drain
    assign advance  = !(valid_reg[DIV_STEPS-1] && q_full);
    assign in_stall = !advance;
    assign push     = valid_reg[DIV_STEPS-1] && advance;
    assign phase    = quo_reg[DIV_STEPS-1];
    assign num_in   = {time_now, {PHASE_BITS{1'b0}}};

    // Compute one divide step per stage
    always_comb
    begin
        step[0] = div_step({CYC_W{1'b0}}, num_in[DIV_STEPS-1], divisor);
        for (int s = 1; s < DIV_STEPS; s++)
        begin
            step[s] = div_step(rem_reg[s-1], num_reg[s-1][DIV_STEPS-1], divisor);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < DIV_STEPS; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // Advance partial remainders, dividend bits and quotient bits
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= step[0].rem;
            num_reg[0] <= num_in << 1;
            quo_reg[0] <= {{(PHASE_BITS-1){1'b0}}, step[0].qbit};
            for (int s = 1; s < DIV_STEPS; s++)
            begin
                rem_reg[s] <= step[s].rem;
                num_reg[s] <= num_reg[s-1] << 1;
                quo_reg[s] <= {quo_reg[s-1][PHASE_BITS-2:0], step[s].qbit};
            end
        end
    end

endmodule

### src/sbw_queue.sv
// ----------------------------------------------------------------------------
// sbw_queue: short phase queue between divider and boxcar summer
// Four-entry FIFO that lets each side stall on its own.
// ----------------------------------------------------------------------------
module sbw_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [sbw_pkg::PHASE_BITS-1:0] push_data,
    input  logic                           pop,
    output logic                           full,
    output logic                           not_empty,
    output logic [sbw_pkg::PHASE_BITS-1:0] head_data
);
    import sbw_pkg::*;

    logic [PHASE_BITS-1:0] data_reg [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = data_reg[rd_ptr_reg];

    // Update pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

### src/sbw_box_sum.sv
// ----------------------------------------------------------------------------
// sbw_box_sum: boxcar window test, height sum and clamp
// Pops one phase per cycle unless a stalled result holds the output register,
// sums active boxcar heights and clamps the sum into the output register.
// ----------------------------------------------------------------------------
module sbw_box_sum (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sbw_pkg::box_cfg_t              cfg,
    input  logic                           q_valid,
    input  logic [sbw_pkg::PHASE_BITS-1:0] q_phase,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [15:0]             drive_value
);
    import sbw_pkg::*;

    logic                    out_valid_reg;
    logic signed [15:0]      drive_reg, drive_next;
    logic signed [SUM_W-1:0] sum;
    logic [PHASE_BITS-1:0]   d, w;
    logic [PHASE_BITS:0]     off;
    logic                    on;

    assign pop         = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid   = out_valid_reg;
    assign drive_value = drive_reg;

    // Test each boxcar window and sum heights of those that are on
    always_comb
    begin
        sum = '0;
        d   = '0;
        w   = '0;
        off = '0;
        on  = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            d   = cfg.delays[16*i+15 -: PHASE_BITS];
            w   = cfg.widths[16*i+15 -: PHASE_BITS];
            off = {1'b0, d} + {1'b0, w};
            if (!off[PHASE_BITS])
            begin
                on = (q_phase > d) && (q_phase < off[PHASE_BITS-1:0]);
            end
            else
            begin
                on = (q_phase < off[PHASE_BITS-1:0]) || (q_phase > d);
            end
            if (on && (3'(i) < cfg.active_boxes))
            begin
                sum = sum + SUM_W'(signed'(cfg.heights[16*i+15 -: 16]));
            end
        end
    end

    // Raise to the lower limit, then cut to the upper limit
    always_comb
    begin
        drive_next = sum[15:0];
        if (sum < SUM_W'(cfg.min_value))
        begin
            drive_next = cfg.min_value;
        end
        if ((sum < SUM_W'(cfg.min_value) ? SUM_W'(cfg.min_value) : sum)
            > SUM_W'(cfg.max_value))
        begin
            drive_next = cfg.max_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= q_valid;
        end
    end

    // Load the result when the output register frees up
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            drive_reg <= drive_next;
        end
    end

endmodule

### src/stacked_boxcar_waveform.sv
// ----------------------------------------------------------------------------
// stacked_boxcar_waveform: stacked boxcar waveform generator
// Maps a time value to a cycle phase and outputs the clamped sum of the
// heights of the boxcars that are on at that phase.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel: in_valid / in_stall carry time_now. One request is taken
//  per cycle while in_stall is low.
//  Output channel: out_valid / out_stall carry drive_value, one result per
//  request, in order.
//  Config port: cfg_we writes cfg_data into register cfg_index; write only
//  while no request is in flight.
//  Path: a request passes the 64 divider stages (the first loaded at
//  acceptance), then the queue and one output register.
//  Throughput: one request per cycle while in_stall is low, set by the
//  64-stage divider pipe that retires one restoring step per stage.
//  Stall: a stalled output holds; the four-entry queue absorbs the divider
//  drain, then in_stall rises and the divider pipe holds in place.
//  Reset: clears the pipe and queue and loads register defaults
//  (cycle time 1, no boxes, limits at full range).
// ----------------------------------------------------------------------------
module stacked_boxcar_waveform (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [63:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sbw_pkg::TIME_W-1:0]  time_now,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [15:0]          drive_value
);
    import sbw_pkg::*;

    logic [CYC_W-1:0]      cycle_time_reg;
    logic [2:0]            active_boxes_reg;
    logic [63:0]           delays_reg;
    logic [63:0]           widths_reg;
    logic [63:0]           heights_reg;
    logic signed [15:0]    min_value_reg;
    logic signed [15:0]    max_value_reg;
    logic [CYC_W-1:0]      divisor;
    box_cfg_t              cfg;
    logic                  q_full;
    logic                  q_not_empty;
    logic                  push;
    logic                  pop;
    logic [PHASE_BITS-1:0] div_phase;
    logic [PHASE_BITS-1:0] head_phase;

    // Treat a zero cycle time as one
    assign divisor = (cycle_time_reg == '0) ? CYC_W'(1) : cycle_time_reg;

    assign cfg.active_boxes = active_boxes_reg;
    assign cfg.delays       = delays_reg;
    assign cfg.widths       = widths_reg;
    assign cfg.heights      = heights_reg;
    assign cfg.min_value    = min_value_reg;
    assign cfg.max_value    = max_value_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_time_reg   <= CYC_W'(1);
            active_boxes_reg <= '0;
            delays_reg       <= '0;
            widths_reg       <= '0;
            heights_reg      <= '0;
            min_value_reg    <= 16'sh8000;
            max_value_reg    <= 16'sh7FFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CYCLE_TIME:   cycle_time_reg   <= cfg_data[CYC_W-1:0];
                REG_ACTIVE_BOXES: active_boxes_reg <= cfg_data[2:0];
                REG_DELAYS:       delays_reg       <= cfg_data;
                REG_WIDTHS:       widths_reg       <= cfg_data;
                REG_HEIGHTS:      heights_reg      <= cfg_data;
                REG_MIN_VALUE:    min_value_reg    <= cfg_data[15:0];
                REG_MAX_VALUE:    max_value_reg    <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    sbw_phase_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .time_now (time_now),
        .divisor  (divisor),
        .q_full   (q_full),
        .push     (push),
        .phase    (div_phase)
    );

    sbw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (div_phase),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_data (head_phase)
    );

    sbw_box_sum u_sum (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_not_empty),
        .q_phase     (head_phase),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive_value (drive_value)
    );

endmodule

### tb/tb_stacked_boxcar_waveform.sv
// ----------------------------------------------------------------------------
// tb_stacked_boxcar_waveform: self-checking bench for the boxcar waveform
// Drives time requests through a valid/stall channel, predicts each clamped
// boxcar sum from a local copy of the registers, and checks results in order
// under random idling on both sides and several register settings.
// ----------------------------------------------------------------------------
module tb_stacked_boxcar_waveform;
    import sbw_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [2:0]               cfg_index;
    logic [63:0]              cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [TIME_W-1:0]        time_now;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [15:0]       drive_value;

    // register shadow used by the predictor
    logic [31:0]              cyc_r;
    logic [2:0]               nbox_r;
    logic [63:0]              dly_r;
    logic [63:0]              wid_r;
    logic [63:0]              hgt_r;
    logic signed [15:0]       min_r;
    logic signed [15:0]       max_r;

    logic [TIME_W-1:0]        time_req_q[$];
    logic signed [15:0]       drive_exp_q[$];
    int                       send_idle_pct;
    int                       recv_idle_pct;
    bit                       hold_requests;
    int                       errors;
    int                       cycles;

    stacked_boxcar_waveform dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .time_now    (time_now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive_value (drive_value)
    );

    always #5 clk = ~clk;

    // Compute the clamped sum of the boxcars that are on at this time
    function automatic logic signed [15:0] boxcar_sum(input logic [TIME_W-1:0] t);
        logic [63:0] cyc;
        logic [63:0] phase;
        logic [16:0] d;
        logic [16:0] w;
        logic [16:0] off;
        int          n;
        int          sum;
        bit          on;
        cyc   = (cyc_r == 0) ? 64'd1 : {32'd0, cyc_r};
        phase = ((64'(t) % cyc) << PHASE_BITS) / cyc;
        n     = (nbox_r > STACK_DEPTH) ? STACK_DEPTH : int'(nbox_r);
        sum   = 0;
        for (int i = 0; i < n; i++)
        begin
            d   = {1'b0, dly_r[16*i +: 16]};
            w   = {1'b0, wid_r[16*i +: 16]};
            off = d + w;
            if (off < 17'h10000)
                on = (phase > d) && (phase < off);
            else
                on = (phase < (off - 17'h10000)) || (phase > d);
            if (on)
                sum += int'($signed(hgt_r[16*i +: 16]));
        end
        if (sum < int'(min_r))
            sum = int'(min_r);
        if (sum > int'(max_r))
            sum = int'(max_r);
        return 16'(sum);
    endfunction

    // Driver: present pending requests, record a prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            time_now <= '0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                drive_exp_q.push_back(boxcar_sum(time_now));
                void'(time_req_q.pop_front());
            end
            if (hold_requests || time_req_q.size() == 0 ||
                $urandom_range(99) < send_idle_pct)
                in_valid <= 1'b0;
            else
            begin
                in_valid <= 1'b1;
                time_now <= time_req_q[0];
            end
        end
    end

    // Monitor: stall at random, check each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_exp_q.size() == 0)
                begin
                    $error("unexpected result drive_value=%0d", drive_value);
                    errors++;
                end
                else if (drive_value !== drive_exp_q[0])
                begin
                    $error("drive_value mismatch: expected %0d, actual %0d",
                           drive_exp_q[0], drive_value);
                    errors++;
                    void'(drive_exp_q.pop_front());
                end
                else
                    void'(drive_exp_q.pop_front());
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_CYCLE_TIME:   cyc_r  = data[31:0];
            REG_ACTIVE_BOXES: nbox_r = data[2:0];
            REG_DELAYS:       dly_r  = data;
            REG_WIDTHS:       wid_r  = data;
            REG_HEIGHTS:      hgt_r  = data;
            REG_MIN_VALUE:    min_r  = data[15:0];
            REG_MAX_VALUE:    max_r  = data[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every request is answered and the pipe has drained
    task automatic wait_idle();
        while (time_req_q.size() != 0 || drive_exp_q.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_cfg(input logic [31:0] c, input logic [2:0] n,
                            input logic [63:0] d, input logic [63:0] w,
                            input logic [63:0] h, input logic [15:0] mn,
                            input logic [15:0] mx);
        wait_idle();
        write_reg(REG_CYCLE_TIME, {32'd0, c});
        write_reg(REG_ACTIVE_BOXES, {61'd0, n});
        write_reg(REG_DELAYS, d);
        write_reg(REG_WIDTHS, w);
        write_reg(REG_HEIGHTS, h);
        write_reg(REG_MIN_VALUE, {48'd0, mn});
        write_reg(REG_MAX_VALUE, {48'd0, mx});
    endtask

    // Time whose phase lands near an edge of box j
    function automatic logic [TIME_W-1:0] edge_time(input int j);
        logic [63:0] cyc;
        logic [15:0] target;
        logic [63:0] t;
        cyc    = (cyc_r == 0) ? 64'd1 : {32'd0, cyc_r};
        target = $urandom_range(1) ? dly_r[16*j +: 16]
                                   : 16'(dly_r[16*j +: 16] + wid_r[16*j +: 16]);
        target = 16'(target + $urandom_range(2) - 1);
        t = ((64'(target) * cyc) + 64'hFFFF) >> 16;
        t = t + $urandom_range(2) + cyc * $urandom_range(1000);
        return TIME_W'(t);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [31:0] c;
        logic [63:0] h;
        logic [15:0] mn;
        logic [15:0] mx;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_CYCLE_TIME;
        cfg_data      = '0;
        in_valid      = 1'b0;
        time_now      = '0;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = 1'b0;
        errors        = 0;
        cycles        = 0;
        cyc_r  = 32'd1;
        nbox_r = 3'd0;
        dly_r  = '0;
        wid_r  = '0;
        hgt_r  = '0;
        min_r  = -16'sd32768;
        max_r  = 16'sd32767;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: no boxes, extremes of time
        time_req_q.push_back('0);
        time_req_q.push_back('1);
        time_req_q.push_back(48'h5555_AAAA_5555);

        // All four boxes on, full-scale heights on two, one wrapping window, phase = t mod 2^16
        load_cfg(32'h10000, 3'd4, 64'hF000_8000_0100_0000,
                 64'h2000_1000_0100_FFFF, 64'h8000_7FFF_0100_FF00,
                 16'h8000, 16'h7FFF);
        time_req_q.push_back(48'h0);     time_req_q.push_back(48'h1);
        time_req_q.push_back(48'hFFFE);  time_req_q.push_back(48'hFFFF);
        time_req_q.push_back(48'h100);   time_req_q.push_back(48'h101);
        time_req_q.push_back(48'h200);   time_req_q.push_back(48'h8000);
        time_req_q.push_back(48'h8FFF);  time_req_q.push_back(48'h0FFF);
        time_req_q.push_back(48'h1000);
        for (int k = 0; k < 13; k++)
            time_req_q.push_back(TIME_W'(k * 4099 + (k[0] ? 48'h1_0000 : 0)));
        time_req_q.push_back(48'h0000_0000_F001);
        time_req_q.push_back(48'h0000_0000_8001);

        // Box count above depth, crossed limits, zero cycle time
        load_cfg(32'd0, 3'd7, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h0100_0100_0100_0100, 16'h0100, 16'hFF00);
        time_req_q.push_back('1);
        time_req_q.push_back(48'd12345);
        load_cfg(32'hFFFF_FFFF, 3'd5, rand64(), rand64(), rand64(),
                 16'h0000, 16'h0000);
        time_req_q.push_back('1);
        time_req_q.push_back(48'hFFFF_FFFE);

        // Random phases: idling pattern shifts through the run
        for (int p = 0; p < 12; p++)
        begin
            case (p % 4)
                0: c = 32'hFFFF_FFFF;
                1: c = $urandom_range(1, 40);
                2: c = $urandom;
                default: c = $urandom_range(0, 1) ? 32'd1 : 32'h10000;
            endcase
            h  = (p % 3 == 0) ? 64'h7FFF_7FFF_8000_8000 : rand64();
            mn = (p % 5 == 0) ? 16'h8000 : 16'($urandom_range(0, 65535));
            mx = (p % 5 == 0) ? 16'h7FFF : 16'($urandom_range(0, 65535));
            if (p % 4 == 1)
            begin
                mn = 16'hC000;
                mx = 16'h4000;
            end
            load_cfg(c, 3'($urandom_range(0, 7)), rand64(), rand64(), h, mn, mx);
            send_idle_pct = (p < 4) ? 33 : (p < 8) ? 69 : 0;
            recv_idle_pct = (p < 4) ? 69 : (p < 8) ? 33 : 0;
            for (int k = 0; k < 45; k++)
            begin
                if ($urandom_range(99) < 60)
                    time_req_q.push_back(edge_time($urandom_range(0, 3)));
                else
                    time_req_q.push_back(TIME_W'(rand64()));
                // hold off until all outstanding results are back
                if (p == 5 && k == 20)
                begin
                    while (time_req_q.size() != 0)
                        @(posedge clk);
                    hold_requests = 1'b1;
                    while (drive_exp_q.size() != 0 || in_valid)
                        @(posedge clk);
                    hold_requests = 1'b0;
                end
            end
        end

        wait_idle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
